/* rtl/core/swsr_pkg.sv */
`timescale 1ns / 1ps
// Package for the LIFO stack with search-and-remove.
// Holds sizes, action/status codes, sequencer states and the RAM request bundle.
package swsr_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   localparam logic signed [WORD_W-1:0] LIMIT_RESET = 32'sd100;
   localparam logic signed [WORD_W-1:0] ZERO_LIMIT  = 32'sd0;

   typedef enum logic [1:0] {
      ACT_PUSH      = 2'd0,
      ACT_POP       = 2'd1,
      ACT_DEL_POS   = 2'd2,
      ACT_DEL_LIMIT = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_NOMATCH = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_WAIT,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

endpackage

/* rtl/core/stack_with_search_removal.sv */
`timescale 1ns / 1ps
// LIFO stack of 64 signed words with pop and search-and-remove actions.
// A push writes at once; a pop reads the top entry; a delete scans from the top down
// for the first match and then shifts the entries above it down to close the gap.
// One item at a time: busy stays high through the result strobe, so the next beat is
// taken the cycle after it; the receiver cannot stall.
// Synchronous reset empties the stack and sets limit_ff to 100; entries keep old data.
module stack_with_search_removal
   import swsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_action,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic                     rsp_strobe,
   output logic signed [WORD_W-1:0] rsp_value,
   output logic [1:0]               rsp_status,
   input  logic                     csr_wr_en,
   input  logic signed [WORD_W-1:0] csr_wr_data
);

   logic signed [WORD_W-1:0] limit_ff;
   ram_req_type              ram_req;
   logic [WORD_W-1:0]        ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   swsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .action     (req_action),
      .push_value (req_push_value),
      .limit      (limit_ff),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   swsr_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

endmodule

/* rtl/core/swsr_ram.sv */
`timescale 1ns / 1ps
// Entry storage for the stack: one write port, one read port, registered read data.
// Depends on swsr_pkg for sizes and the request bundle.
module swsr_ram
   import swsr_pkg::*;
(
   input  logic              clock,
   input  ram_req_type       req,
   output logic [WORD_W-1:0] rdata
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      rdata_ff <= mem[req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/swsr_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the stack: push/pop, top-down scan with one shared signed
// compare, and a one-entry-per-cycle shift that closes the gap. Uses swsr_pkg.
module swsr_ctrl
   import swsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               action,
   input  logic signed [WORD_W-1:0] push_value,
   input  logic signed [WORD_W-1:0] limit,
   output ram_req_type              ram_req,
   input  logic [WORD_W-1:0]        ram_rdata,
   output logic                     rsp_strobe,
   output logic signed [WORD_W-1:0] rsp_value,
   output logic [1:0]               rsp_status
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   action_type        act_ff, act_in;
   logic [WORD_W-1:0] val_ff, val_in;
   status_type        status_ff, status_in;

   logic              empty;
   logic              full;
   logic [CNT_W-1:0]  fill_m1;
   logic [CNT_W-1:0]  idx_p1;
   logic [CNT_W-1:0]  idx_p2;
   logic signed [WORD_W-1:0] cmp_limit;
   logic              hit;

   assign empty   = (fill_ff == '0);
   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign fill_m1 = fill_ff - CNT_W'(1);
   assign idx_p1  = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_p2  = CNT_W'(idx_ff) + CNT_W'(2);

   // shared compare: entry strictly above the selected limit
   assign cmp_limit = (act_ff == ACT_DEL_POS) ? ZERO_LIMIT : limit;
   assign hit       = $signed(ram_rdata) > cmp_limit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (action_type'(action))
                  ACT_PUSH: state_in = S_DONE;
                  ACT_POP:  state_in = empty ? S_DONE : S_POP_WAIT;
                  default:  state_in = empty ? S_DONE : S_SCAN;
               endcase
            end
         end
         S_POP_WAIT: state_in = S_DONE;
         S_SCAN: begin
            if (hit) begin
               state_in = (idx_p1 < fill_ff) ? S_SHIFT : S_DONE;
            end else if (idx_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            if (idx_p2 >= fill_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      act_in        = act_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = fill_ff[ADDR_W-1:0];
      ram_req.wdata = push_value;
      ram_req.raddr = fill_m1[ADDR_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in    = action_type'(action);
               val_in    = '0;
               status_in = ST_OK;
               idx_in    = fill_m1[ADDR_W-1:0];
               unique case (action_type'(action))
                  ACT_PUSH: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_req.we = 1'b1;
                        fill_in    = fill_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        fill_in = fill_m1;
                     end
                  end
                  default: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end
                  end
               endcase
            end
         end
         S_POP_WAIT: val_in = ram_rdata;
         S_SCAN: begin
            if (hit) begin
               val_in        = ram_rdata;
               ram_req.raddr = idx_p1[ADDR_W-1:0];
               if (idx_p1 >= fill_ff) begin
                  fill_in = fill_m1;
               end
            end else if (idx_ff == '0) begin
               status_in = ST_NOMATCH;
            end else begin
               // step down one entry
               idx_in        = idx_ff - ADDR_W'(1);
               ram_req.raddr = idx_ff - ADDR_W'(1);
            end
         end
         S_SHIFT: begin
            // move entry idx+1 down into idx, fetch the next one
            ram_req.we    = 1'b1;
            ram_req.waddr = idx_ff;
            ram_req.wdata = ram_rdata;
            ram_req.raddr = idx_p2[ADDR_W-1:0];
            idx_in        = idx_p1[ADDR_W-1:0];
            if (idx_p2 >= fill_ff) begin
               fill_in = fill_m1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      idx_ff    <= idx_in;
      act_ff    <= act_in;
      val_ff    <= val_in;
      status_ff <= status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);
   assign rsp_value  = $signed(val_ff);
   assign rsp_status = status_ff;

endmodule
